// ----- rtl/core/wcm_pkg.sv -----
// Shared constants, opcode codes and controller states of the wavetable mixer.
`timescale 1ns / 1ps

package wcm_pkg;

   localparam int CHANNELS_DEF         = 16;
   localparam int SAMPLE_MEM_BYTES_DEF = 262144;
   localparam int FRAC_BITS_DEF        = 10;

   localparam int OP_W      = 2;
   localparam int CHAN_W    = 4;
   localparam int ADDR_W    = 18;
   localparam int BYTE_W    = 8;
   localparam int STEP_W    = 20;
   localparam int GAIN_W    = 9;
   localparam int OUT_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 5;

   localparam logic [CSR_W-1:0] CHANNEL_COUNT_RESET = 5'd4;
   localparam logic [7:0]       OFFSET_BINARY_BIAS  = 8'h80;

   typedef enum logic [OP_W-1:0] {
      OP_MIX   = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2,
      OP_PITCH = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_STEREO_MODE   = 2'd1,
      CSR_WIDE_SAMPLES  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CH_MERGE,
      ST_MX_CHRD,
      ST_MX_S0,
      ST_MX_S1,
      ST_MX_INT,
      ST_MX_GAIN,
      ST_MX_WB,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_END,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/wavetable_channel_mixer.sv -----
// Top level of the wavetable channel mixer: request decode, channel walk and averaging.
`timescale 1ns / 1ps

//  channel | ports                        | handshake
//  request | req_* opcode, channel, data  | req_valid / req_ready
//  result  | rsp_right_or_mono, left_out  | rsp_valid / rsp_ready
//  config  | csr_wr_en, index, data       | write when csr_wr_en is high
//
// A sample write goes to memory on acceptance; a start or pitch update is merged
// into its channel entry in ST_CH_MERGE. A mix walks CHRD, S0, S1, INT, GAIN, WB per
// active channel (CHRD, S0, WB when silent), since the single sample memory port reads
// two bytes per channel, plus two bit-serial divisions in stereo (one in mono).
// Synchronous reset clears the channel table through per-entry valid bits; sample
// memory is not cleared. A waiting result does not block new requests.

module wavetable_channel_mixer
   import wcm_pkg::*;
#(
   parameter int CHANNELS         = wcm_pkg::CHANNELS_DEF,
   parameter int SAMPLE_MEM_BYTES = wcm_pkg::SAMPLE_MEM_BYTES_DEF,
   parameter int FRAC_BITS        = wcm_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [wcm_pkg::OP_W-1:0]       req_opcode,
   input  logic [wcm_pkg::CHAN_W-1:0]     req_chan,
   input  logic [wcm_pkg::ADDR_W-1:0]     req_mem_address,
   input  logic [wcm_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic [wcm_pkg::ADDR_W-1:0]     req_sample_length,
   input  logic [wcm_pkg::ADDR_W-1:0]     req_loop_begin,
   input  logic [wcm_pkg::ADDR_W-1:0]     req_loop_finish,
   input  logic [wcm_pkg::ADDR_W-1:0]     req_start_offset,
   input  logic [wcm_pkg::STEP_W-1:0]     req_step_size,
   input  logic [wcm_pkg::GAIN_W-1:0]     req_gain,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [wcm_pkg::OUT_W-1:0]      rsp_right_or_mono,
   output logic [wcm_pkg::OUT_W-1:0]      rsp_left_out,
   input  logic                           csr_wr_en,
   input  logic [wcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wcm_pkg::CSR_W-1:0]      csr_wr_data
);

   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int XCW       = (CH_IDX_W > CHAN_W) ? CH_IDX_W : CHAN_W;
   localparam int N_W       = $clog2(CHANNELS + 1);
   localparam int POS_W     = ADDR_W + FRAC_BITS;
   localparam int MEM_AW    = $clog2(SAMPLE_MEM_BYTES);
   localparam int SUM_W     = (MEM_AW > ADDR_W + 2) ? MEM_AW : ADDR_W + 2;
   localparam int INTERP_W  = 10;
   localparam int CONTRIB_W = 18;
   localparam int ACC_W     = CONTRIB_W + N_W;
   localparam int NUM_W     = ACC_W + 5;
   localparam int DCNT_W    = $clog2(NUM_W);

   typedef struct packed {
      logic                        active;
      logic signed [CONTRIB_W-1:0] last;
      logic [GAIN_W-1:0]           gain;
      logic [STEP_W-1:0]           step;
      logic [ADDR_W-1:0]           base;
      logic [POS_W-1:0]            pos;
      logic [POS_W-1:0]            endp;
      logic [POS_W-1:0]            lstart;
      logic [POS_W-1:0]            lend;
   } chan_rec_type;

   localparam int REC_W = $bits(chan_rec_type);

   // Control registers.
   state_type                 state_ff, state_in;
   logic [CSR_W-1:0]          cfg_count_ff;
   logic                      cfg_stereo_ff, cfg_wide_ff;
   logic [CHANNELS-1:0]       written_ff, written_in;
   logic [CH_IDX_W-1:0]       idx_ff, idx_in;
   logic                      pass_ff, pass_in;
   logic [DCNT_W-1:0]         dcnt_ff, dcnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   opcode_type                op_ff;
   logic [CHAN_W-1:0]         chan_ff;
   logic [ADDR_W-1:0]         addr_ff, len_ff, lb_ff, lf_ff, so_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [N_W-1:0]            n_ff, n_in;
   logic signed [BYTE_W-1:0]  s0_ff, s0_in;
   logic signed [INTERP_W-1:0] interp_ff, interp_in;
   logic signed [CONTRIB_W-1:0] v_ff, v_in;
   logic signed [ACC_W-1:0]   right_ff, right_in, left_ff, left_in;
   logic [NUM_W-1:0]          dvd_ff, dvd_in;
   logic [N_W-1:0]            rem_ff, rem_in;
   logic                      neg_ff, neg_in;
   logic [OUT_W-1:0]          res_r_ff, res_r_in, res_l_ff, res_l_in;
   logic [OUT_W-1:0]          rsp_r_ff, rsp_r_in, rsp_l_ff, rsp_l_in;
   logic                      ch_ok_ff;

   // Memory ports.
   logic                      smp_wr_en, smp_rd_en;
   logic [MEM_AW-1:0]         smp_wr_addr, smp_rd_addr;
   logic [BYTE_W-1:0]         smp_rd_data;
   logic                      ch_wr_en, ch_rd_en;
   logic [CH_IDX_W-1:0]       ch_wr_addr, ch_rd_addr;
   logic [REC_W-1:0]          ch_rd_data;
   chan_rec_type              rec, rec_wb;

   logic                      req_fire;
   logic [XCW-1:0]            chan_x, idx_x;
   logic [SUM_W-1:0]          wr_x, rd_x;
   logic [N_W-1:0]            n_calc;
   logic                      to_right, last_chan;
   logic signed [BYTE_W:0]    diff;
   logic signed [FRAC_BITS+BYTE_W+1:0] prod, prod_sh;
   logic signed [INTERP_W+GAIN_W:0]    gprod;
   logic [POS_W:0]            pos_sum, pos_wrap;
   logic signed [CONTRIB_W-1:0] contrib;
   logic signed [NUM_W-1:0]   rw, lw, num;
   logic [NUM_W-1:0]          mag;
   logic [N_W:0]              rem_sh;
   logic                      qbit;
   logic [NUM_W-1:0]          quot;
   logic [OUT_W-1:0]          q16;

   function automatic logic [OUT_W-1:0] pack_out(input logic [OUT_W-1:0] v, input logic wide);
      if (wide) begin
         return v;
      end
      return {8'h00, v[15:8] + OFFSET_BINARY_BIAS};
   endfunction

   wcm_ram #(.WIDTH(BYTE_W), .DEPTH(SAMPLE_MEM_BYTES)) u_sample_ram (
      .clock   (clock),
      .wr_en   (smp_wr_en),
      .wr_addr (smp_wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (smp_rd_en),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_rd_data)
   );

   wcm_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS)) u_chan_ram (
      .clock   (clock),
      .wr_en   (ch_wr_en),
      .wr_addr (ch_wr_addr),
      .wr_data (rec_wb),
      .rd_en   (ch_rd_en),
      .rd_addr (ch_rd_addr),
      .rd_data (ch_rd_data)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign req_fire          = req_valid && req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_right_or_mono = rsp_r_ff;
   assign rsp_left_out      = rsp_l_ff;

   // Entries never written since reset read as all zero.
   assign rec    = ch_ok_ff ? chan_rec_type'(ch_rd_data) : chan_rec_type'('0);
   assign chan_x = XCW'(chan_ff);
   assign idx_x  = XCW'(idx_ff);

   // Sample writes go straight from the request ports.
   assign wr_x        = SUM_W'(req_mem_address);
   assign smp_wr_en   = req_fire && (opcode_type'(req_opcode) == OP_WRITE);
   assign smp_wr_addr = wr_x[MEM_AW-1:0];

   assign rd_x = SUM_W'(rec.base) + SUM_W'(rec.pos[POS_W-1:FRAC_BITS])
               + SUM_W'(state_ff == ST_MX_S1);
   assign smp_rd_en   = (state_ff == ST_MX_S0) || (state_ff == ST_MX_S1);
   assign smp_rd_addr = rd_x[MEM_AW-1:0];

   assign n_calc = (cfg_count_ff == '0) ? N_W'(1)
                 : (int'(cfg_count_ff) > CHANNELS) ? N_W'(CHANNELS)
                 : N_W'(cfg_count_ff);

   assign to_right  = (int'(n_ff) == 4) ? (idx_x[1:0] == 2'd1 || idx_x[1:0] == 2'd2)
                                        : !idx_x[0];
   assign last_chan = (N_W'(idx_ff) + N_W'(1)) >= n_ff;

   // Interpolation: s0 + floor(frac * (s1 - s0) / 2^FRAC_BITS).
   assign diff    = $signed({smp_rd_data[BYTE_W-1], smp_rd_data}) - $signed({s0_ff[BYTE_W-1], s0_ff});
   assign prod    = $signed({1'b0, rec.pos[FRAC_BITS-1:0]}) * diff;
   assign prod_sh = prod >>> FRAC_BITS;
   assign gprod   = interp_ff * $signed({1'b0, rec.gain});

   assign pos_sum  = {1'b0, rec.pos} + (POS_W+1)'(rec.step);
   assign pos_wrap = (POS_W+1)'(pos_sum[FRAC_BITS-1:0]) + {1'b0, rec.lstart};
   assign contrib  = rec.active ? v_ff : rec.last;

   assign rw   = NUM_W'(right_ff);
   assign lw   = NUM_W'(left_ff);
   assign rem_sh = {rem_ff, dvd_ff[NUM_W-1]};
   assign qbit   = rem_sh >= (N_W+1)'(n_ff);
   assign quot   = neg_ff ? (~dvd_ff + NUM_W'(1)) : dvd_ff;
   assign q16    = quot[OUT_W-1:0];

   always_comb begin
      num = '0;
      if (!cfg_stereo_ff) begin
         num = rw + lw;
      end else if (!pass_ff) begin
         num = NUM_W'(rw * 13) + NUM_W'(lw * 3);
      end else begin
         num = NUM_W'(lw * 13) + NUM_W'(rw * 3);
      end
      mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      // The stereo divisor 8n is applied as a shift followed by division by n.
      if (cfg_stereo_ff) begin
         mag = mag >> 3;
      end
   end

   always_comb begin
      state_in     = state_ff;
      written_in   = written_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      n_in         = n_ff;
      s0_in        = s0_ff;
      interp_in    = interp_ff;
      v_in         = v_ff;
      right_in     = right_ff;
      left_in      = left_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      res_r_in     = res_r_ff;
      res_l_in     = res_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_l_in     = rsp_l_ff;
      ch_rd_en     = 1'b0;
      ch_rd_addr   = idx_ff;
      ch_wr_en     = 1'b0;
      ch_wr_addr   = idx_ff;
      rec_wb       = rec;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (opcode_type'(req_opcode))
                  OP_MIX: begin
                     n_in     = n_calc;
                     idx_in   = '0;
                     right_in = '0;
                     left_in  = '0;
                     pass_in  = 1'b0;
                     state_in = ST_MX_CHRD;
                  end
                  OP_START, OP_PITCH: begin
                     if (int'(req_chan) < CHANNELS) begin
                        ch_rd_en   = 1'b1;
                        ch_rd_addr = CH_IDX_W'(req_chan);
                        state_in   = ST_CH_MERGE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CH_MERGE: begin
            if (op_ff == OP_START) begin
               rec_wb.base   = addr_ff;
               rec_wb.endp   = {len_ff, FRAC_BITS'(0)};
               rec_wb.lstart = {lb_ff, FRAC_BITS'(0)};
               rec_wb.lend   = {lf_ff, FRAC_BITS'(0)};
               rec_wb.pos    = {so_ff, FRAC_BITS'(0)};
               rec_wb.active = (len_ff != '0);
            end else begin
               rec_wb.step = step_ff;
               rec_wb.gain = gain_ff;
            end
            ch_wr_en   = 1'b1;
            ch_wr_addr = chan_x[CH_IDX_W-1:0];
            written_in[chan_x[CH_IDX_W-1:0]] = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_MX_CHRD: begin
            ch_rd_en = 1'b1;
            state_in = ST_MX_S0;
         end
         ST_MX_S0: begin
            state_in = rec.active ? ST_MX_S1 : ST_MX_WB;
         end
         ST_MX_S1: begin
            s0_in    = smp_rd_data;
            state_in = ST_MX_INT;
         end
         ST_MX_INT: begin
            interp_in = INTERP_W'(s0_ff) + INTERP_W'(prod_sh);
            state_in  = ST_MX_GAIN;
         end
         ST_MX_GAIN: begin
            v_in     = CONTRIB_W'(gprod);
            state_in = ST_MX_WB;
         end
         ST_MX_WB: begin
            if (rec.active) begin
               rec_wb.last = v_ff;
               // Past the end: the loop end becomes the end and play resumes at the loop start.
               if (pos_sum >= {1'b0, rec.endp}) begin
                  rec_wb.endp   = rec.lend;
                  rec_wb.pos    = pos_wrap[POS_W-1:0];
                  rec_wb.active = (rec.lend != '0);
               end else begin
                  rec_wb.pos = pos_sum[POS_W-1:0];
               end
               ch_wr_en = 1'b1;
               written_in[idx_ff] = 1'b1;
            end
            if (to_right) begin
               right_in = right_ff + ACC_W'(contrib);
            end else begin
               left_in = left_ff + ACC_W'(contrib);
            end
            if (last_chan) begin
               state_in = ST_DIV_LOAD;
            end else begin
               idx_in   = idx_ff + CH_IDX_W'(1);
               state_in = ST_MX_CHRD;
            end
         end
         ST_DIV_LOAD: begin
            dvd_in   = mag;
            neg_in   = num[NUM_W-1];
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            rem_in  = qbit ? N_W'(rem_sh - (N_W+1)'(n_ff)) : N_W'(rem_sh);
            dvd_in  = {dvd_ff[NUM_W-2:0], qbit};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (int'(dcnt_ff) == NUM_W - 1) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            if (!pass_ff) begin
               res_r_in = pack_out(q16, cfg_wide_ff);
               res_l_in = '0;
            end else begin
               res_l_in = pack_out(q16, cfg_wide_ff);
            end
            if (cfg_stereo_ff && !pass_ff) begin
               pass_in  = 1'b1;
               state_in = ST_DIV_LOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_r_in     = res_r_ff;
               rsp_l_in     = res_l_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         written_ff    <= '0;
         idx_ff        <= '0;
         pass_ff       <= 1'b0;
         dcnt_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         cfg_count_ff  <= CHANNEL_COUNT_RESET;
         cfg_stereo_ff <= 1'b1;
         cfg_wide_ff   <= 1'b1;
         ch_ok_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         written_ff   <= written_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ch_rd_en) begin
            ch_ok_ff <= written_ff[ch_rd_addr];
         end
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_CHANNEL_COUNT: cfg_count_ff  <= csr_wr_data;
               CSR_STEREO_MODE:   cfg_stereo_ff <= csr_wr_data[0];
               CSR_WIDE_SAMPLES:  cfg_wide_ff   <= csr_wr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= opcode_type'(req_opcode);
         chan_ff <= req_chan;
         addr_ff <= req_mem_address;
         len_ff  <= req_sample_length;
         lb_ff   <= req_loop_begin;
         lf_ff   <= req_loop_finish;
         so_ff   <= req_start_offset;
         step_ff <= req_step_size;
         gain_ff <= req_gain;
      end
      n_ff      <= n_in;
      s0_ff     <= s0_in;
      interp_ff <= interp_in;
      v_ff      <= v_in;
      right_ff  <= right_in;
      left_ff   <= left_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      res_r_ff  <= res_r_in;
      res_l_ff  <= res_l_in;
      rsp_r_ff  <= rsp_r_in;
      rsp_l_ff  <= rsp_l_in;
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("request accepted outside idle");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MX_CHRD |-> N_W'(idx_ff) < n_ff)
      else $error("channel walk past channel count");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_RUN |-> int'(dcnt_ff) < NUM_W)
      else $error("divider ran too long");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done state");

endmodule

// ----- rtl/core/wcm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module wcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- tb/wavetable_channel_mixer_tb.sv -----
// Self-checking testbench for the wavetable channel mixer with a cycle-free frame predictor.
`timescale 1ns / 1ps

module wavetable_channel_mixer_tb;
   import wcm_pkg::*;

   localparam int NUM_CH       = 16;
   localparam int MEM_BYTES    = 262144;
   localparam int FRAC         = 10;
   localparam int STALL_LIMIT  = 20000;
   localparam int SETTLE_TICKS = 300;

   typedef struct {
      opcode_type        op;
      logic [3:0]        chan;
      logic [17:0]       addr;
      logic [7:0]        data;
      logic [17:0]       len;
      logic [17:0]       lp_begin;
      logic [17:0]       lp_finish;
      logic [17:0]       start_ofs;
      logic [19:0]       step;
      logic [8:0]        gain;
   } mixer_request_type;

   typedef struct {
      logic [15:0] right_or_mono;
      logic [15:0] left_out;
   } frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0]   req_opcode = '0;
   logic [CHAN_W-1:0] req_chan = '0;
   logic [ADDR_W-1:0] req_mem_address = '0;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic [ADDR_W-1:0] req_sample_length = '0;
   logic [ADDR_W-1:0] req_loop_begin = '0;
   logic [ADDR_W-1:0] req_loop_finish = '0;
   logic [ADDR_W-1:0] req_start_offset = '0;
   logic [STEP_W-1:0] req_step_size = '0;
   logic [GAIN_W-1:0] req_gain = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_W-1:0] rsp_right_or_mono;
   logic [OUT_W-1:0] rsp_left_out;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   // Predictor state.
   logic [7:0]  sample_mem [0:MEM_BYTES-1];
   logic [27:0] ch_pos [NUM_CH];
   logic [27:0] ch_end [NUM_CH];
   logic [27:0] ch_loop_start [NUM_CH];
   logic [27:0] ch_loop_end [NUM_CH];
   logic [17:0] ch_base [NUM_CH];
   logic [19:0] ch_step [NUM_CH];
   logic [8:0]  ch_gain [NUM_CH];
   bit          ch_on [NUM_CH];
   int          ch_last [NUM_CH];
   logic [4:0]  cfg_count;
   bit          cfg_stereo;
   bit          cfg_wide;

   frame_type expected_frames[$];
   int     error_count = 0;
   bit     no_gaps = 1'b0;
   int     idle_cycles = 0;

   wavetable_channel_mixer dut (.*);

   always #5 clock = ~clock;

   function automatic logic [15:0] pack_sample(longint v);
      logic [15:0] u;
      u = v[15:0];
      return cfg_wide ? u : {8'h00, u[15:8] + 8'h80};
   endfunction

   function automatic void mix_frame();
      int     n;
      bit     to_right;
      longint right, left, p, s0, s1, frac, interp, d;
      int     v;
      logic [17:0] a;
      frame_type f;
      right = 0;
      left = 0;
      n = (cfg_count == 0) ? 1 : ((cfg_count > NUM_CH) ? NUM_CH : int'(cfg_count));
      for (int i = 0; i < n; i++) begin
         to_right = (n == 4) ? (i == 1 || i == 2) : (i % 2 == 0);
         if (ch_on[i]) begin
            p = longint'(ch_pos[i]);
            a = ch_base[i] + ch_pos[i][27:FRAC];
            s0 = longint'($signed(sample_mem[a]));
            s1 = longint'($signed(sample_mem[18'(a + 18'd1)]));
            frac = longint'(ch_pos[i][FRAC-1:0]);
            interp = s0 + ((frac * (s1 - s0)) >>> FRAC);
            v = int'(interp * longint'(ch_gain[i]));
            ch_last[i] = v;
            p = p + longint'(ch_step[i]);
            if (p >= longint'(ch_end[i])) begin
               ch_end[i] = ch_loop_end[i];
               p = (p & 1023) + longint'(ch_loop_start[i]);
               if (ch_end[i] == 0) ch_on[i] = 1'b0;
            end
            ch_pos[i] = p[27:0];
         end else begin
            v = ch_last[i];
         end
         if (to_right) right += v;
         else left += v;
      end
      if (cfg_stereo) begin
         d = longint'(n) * 8;
         f.right_or_mono = pack_sample((right * 13 + left * 3) / d);
         f.left_out = pack_sample((left * 13 + right * 3) / d);
      end else begin
         f.right_or_mono = pack_sample((right + left) / longint'(n));
         f.left_out = '0;
      end
      expected_frames.push_back(f);
   endfunction

   function automatic void apply_request(mixer_request_type r);
      case (r.op)
         OP_WRITE: sample_mem[r.addr] = r.data;
         OP_START: begin
            ch_base[r.chan] = r.addr;
            ch_end[r.chan] = {r.len, 10'd0};
            ch_loop_start[r.chan] = {r.lp_begin, 10'd0};
            ch_loop_end[r.chan] = {r.lp_finish, 10'd0};
            ch_pos[r.chan] = {r.start_ofs, 10'd0};
            ch_on[r.chan] = (r.len != 0);
         end
         OP_PITCH: begin
            ch_step[r.chan] = r.step;
            ch_gain[r.chan] = r.gain;
         end
         default: mix_frame();
      endcase
   endfunction

   task automatic send_request(mixer_request_type r);
      while (!no_gaps && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_chan <= r.chan;
      req_mem_address <= r.addr;
      req_data_byte <= r.data;
      req_sample_length <= r.len;
      req_loop_begin <= r.lp_begin;
      req_loop_finish <= r.lp_finish;
      req_start_offset <= r.start_ofs;
      req_step_size <= r.step;
      req_gain <= r.gain;
      do @(posedge clock); while (!req_ready);
      apply_request(r);
   endtask

   function automatic mixer_request_type blank_request(opcode_type op);
      mixer_request_type r;
      r = '{op: op, chan: 4'($urandom), addr: 18'($urandom), data: 8'($urandom),
            len: 18'($urandom), lp_begin: 18'($urandom), lp_finish: 18'($urandom),
            start_ofs: 18'($urandom), step: 20'($urandom), gain: 9'($urandom)};
      return r;
   endfunction

   // Channel starts whose reads stay inside the preloaded sample regions.
   function automatic mixer_request_type safe_start(int ch);
      mixer_request_type r;
      r = blank_request(OP_START);
      r.chan = 4'(ch);
      if ($urandom_range(9) == 0) begin
         r.addr = 18'($urandom_range(MEM_BYTES - 1, MEM_BYTES - 8));
         r.len = 18'($urandom_range(5));
         r.lp_begin = 18'($urandom_range(5));
         r.lp_finish = 18'($urandom_range(5));
         r.start_ofs = 18'($urandom_range(5));
      end else begin
         r.addr = 18'($urandom_range(127));
         r.len = 18'($urandom_range(100, 1));
         r.lp_begin = 18'($urandom_range(100));
         r.lp_finish = ($urandom_range(3) == 0) ? 18'd0 : 18'($urandom_range(100));
         r.start_ofs = 18'($urandom_range(100));
      end
      return r;
   endfunction

   function automatic mixer_request_type random_pitch(int ch);
      mixer_request_type r;
      int sel;
      r = blank_request(OP_PITCH);
      r.chan = 4'(ch);
      sel = $urandom_range(9);
      if (sel < 7) r.step = 20'($urandom_range(2047));
      else if (sel < 9) r.step = 20'($urandom_range(20000));
      return r;
   endfunction

   task automatic send_op(opcode_type op, int ch, int addr, int data);
      mixer_request_type r;
      r = blank_request(op);
      r.chan = 4'(ch);
      r.addr = 18'(addr);
      r.data = 8'(data);
      send_request(r);
   endtask

   task automatic send_start(int ch, int addr, int len, int lb, int lf, int so);
      mixer_request_type r;
      r = blank_request(OP_START);
      r.chan = 4'(ch);
      r.addr = 18'(addr);
      r.len = 18'(len);
      r.lp_begin = 18'(lb);
      r.lp_finish = 18'(lf);
      r.start_ofs = 18'(so);
      send_request(r);
   endtask

   task automatic send_pitch(int ch, int step, int gain);
      mixer_request_type r;
      r = blank_request(OP_PITCH);
      r.chan = 4'(ch);
      r.step = 20'(step);
      r.gain = 9'(gain);
      send_request(r);
   endtask

   // The last request has already been accepted, so valid drops right away.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= 5'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_CHANNEL_COUNT: cfg_count = 5'(value);
         CSR_STEREO_MODE:   cfg_stereo = value[0];
         default:           cfg_wide = value[0];
      endcase
   endtask

   task automatic test_preload();
      for (int a = 0; a < 256; a++) send_op(OP_WRITE, 0, a, $urandom);
      for (int a = MEM_BYTES - 8; a < MEM_BYTES; a++) send_op(OP_WRITE, 0, a, $urandom);
   endtask

   task automatic test_directed();
      send_op(OP_WRITE, 0, 0, 8'h7F);
      send_op(OP_WRITE, 0, 1, 8'h80);
      send_op(OP_WRITE, 0, 2, 8'hFF);
      send_op(OP_WRITE, 0, MEM_BYTES - 1, 8'h00);
      // A short one-shot sample that falls silent after its end.
      send_start(0, 0, 4, 0, 0, 0);
      send_pitch(0, 1024, 256);
      // Loop shorter than the step, so the position overshoots the loop end.
      send_start(1, 5, 20, 10, 12, 3);
      send_pitch(1, 5000, 200);
      // Zero length keeps the channel inactive.
      send_start(2, 50, 0, 0, 0, 0);
      // Sample straddling the top of memory, so addresses wrap.
      send_start(3, MEM_BYTES - 2, 3, 0, 3, 0);
      send_pitch(3, 300, 511);
      // Field extremes on a channel outside the mixed range.
      send_start(15, MEM_BYTES - 1, 131072, 131072, 131072, 131072);
      send_pitch(15, 1048575, 0);
      repeat (8) send_op(OP_MIX, 0, 0, 0);
      wait_drained();
   endtask

   task automatic test_random_phase(int count, int stereo, int wide, int items);
      int sel;
      write_csr(CSR_CHANNEL_COUNT, count);
      write_csr(CSR_STEREO_MODE, stereo);
      write_csr(CSR_WIDE_SAMPLES, wide);
      for (int c = 0; c < NUM_CH; c++) begin
         send_request(safe_start(c));
         send_request(random_pitch(c));
      end
      for (int k = 0; k < items; k++) begin
         sel = $urandom_range(99);
         if (sel < 45) send_op(OP_MIX, 0, 0, 0);
         else if (sel < 65) send_op(OP_WRITE, 0, $urandom_range(255), $urandom);
         else if (sel < 70) send_op(OP_WRITE, 0, $urandom, $urandom);
         else if (sel < 82) send_request(safe_start($urandom_range(NUM_CH - 1)));
         else send_request(random_pitch($urandom_range(NUM_CH - 1)));
      end
      wait_drained();
   endtask

   always @(posedge clock) rsp_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 37);

   always @(posedge clock) begin
      frame_type f;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            $error("unexpected frame: right_or_mono %h left_out %h",
                   rsp_right_or_mono, rsp_left_out);
            error_count++;
         end else begin
            f = expected_frames.pop_front();
            if (rsp_right_or_mono !== f.right_or_mono) begin
               $error("right_or_mono expected %h actual %h", f.right_or_mono,
                      rsp_right_or_mono);
               error_count++;
            end
            if (rsp_left_out !== f.left_out) begin
               $error("left_out expected %h actual %h", f.left_out, rsp_left_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < MEM_BYTES; i++) sample_mem[i] = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         ch_pos[i] = '0;
         ch_end[i] = '0;
         ch_loop_start[i] = '0;
         ch_loop_end[i] = '0;
         ch_base[i] = '0;
         ch_step[i] = '0;
         ch_gain[i] = '0;
         ch_on[i] = 1'b0;
         ch_last[i] = 0;
      end
      cfg_count = CHANNEL_COUNT_RESET;
      cfg_stereo = 1'b1;
      cfg_wide = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_preload();
      test_directed();
      no_gaps = 1'b1;
      test_random_phase(16, 1, 1, 140);
      no_gaps = 1'b0;
      test_random_phase(1, 0, 1, 117);
      test_random_phase(0, 1, 0, 117);
      test_random_phase(31, 0, 0, 117);
      test_random_phase(4, 0, 0, 117);
      test_random_phase(7, 1, 1, 117);
      test_random_phase(2, 1, 0, 117);
      test_random_phase(16, 0, 1, 117);
      test_random_phase(4, 1, 1, 117);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/wcm_pkg.sv
rtl/core/wcm_ram.sv
rtl/core/wavetable_channel_mixer.sv
tb/wavetable_channel_mixer_tb.sv
